FILE: design/b2d_pkg.sv
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants, types and helpers of the binary to decimal digit core.
// ----------------------------------------------------------------------------
package b2d_pkg;

	localparam int VALUE_BITS = 16;
	localparam int RADIX      = 10;
	localparam int DIGIT_BITS = 4;
	// shift-add iterations done by one pipeline stage
	localparam int DD_STEPS   = 4;
	localparam int STAGES     = (VALUE_BITS + DD_STEPS - 1) / DD_STEPS;
	localparam int PAD_BITS   = STAGES * DD_STEPS;

	localparam logic [5:0]            ASCII_ZERO  = 6'd48;
	localparam logic [DIGIT_BITS-1:0] DIGIT_LIMIT = 4'd5;
	localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ   = 4'd3;

	// decimal digits needed for the largest value
	function automatic int num_digits(input int bits);
		longint v;
		int     n;
		v = (longint'(1) << bits) - 1;
		n = 0;
		while (v != 0) begin
			v = v / RADIX;
			n++;
		end
		return n;
	endfunction

	localparam int DIGITS = num_digits(VALUE_BITS);
	localparam int IDX_W  = $clog2(DIGITS);

	typedef logic [DIGITS-1:0][DIGIT_BITS-1:0] bcd_t;
	typedef logic [IDX_W-1:0]                  idx_t;

	typedef struct packed {
		bcd_t                bcd;
		logic [PAD_BITS-1:0] bin;
	} dd_word_t;

	// position of the most significant nonzero digit, zero for a zero value
	function automatic idx_t msd_index(input bcd_t b);
		idx_t r;
		r = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (b[d] != '0) begin
				r = IDX_W'(d);
			end
		end
		return r;
	endfunction

endpackage

FILE: design/b2d_if.sv
// ----------------------------------------------------------------------------
// b2d_if
// Valid/ready channels of the core: binary operand in, digit items out.
// ----------------------------------------------------------------------------
interface b2d_value_if;
	import b2d_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface b2d_digit_if;
	logic       valid;
	logic       ready;
	logic [5:0] digit_char;
	logic       last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink   (input valid, input digit_char, input last, output ready);
endinterface

FILE: design/b2d_dabble_stage.sv
// ----------------------------------------------------------------------------
// b2d_dabble_stage
// One registered stage of the shift-add-3 conversion, a fixed number of
// binary bits moved into the decimal digits per stage.
// ----------------------------------------------------------------------------
module b2d_dabble_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  b2d_pkg::dd_word_t in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output b2d_pkg::dd_word_t out_word
);
	import b2d_pkg::*;

	logic     valid_s1;
	dd_word_t word_s1;
	dd_word_t next_word;

	always_comb begin
		next_word = in_word;
		for (int k = 0; k < DD_STEPS; k++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (next_word.bcd[d] >= DIGIT_LIMIT) begin
					next_word.bcd[d] = next_word.bcd[d] + DIGIT_ADJ;
				end
			end
			next_word = dd_word_t'(next_word << 1);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= next_word;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

FILE: design/b2d_serializer.sv
// ----------------------------------------------------------------------------
// b2d_serializer
// Holds one converted value and sends its digits as ASCII items, most
// significant first, leading zeros dropped.
// ----------------------------------------------------------------------------
module b2d_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  b2d_pkg::bcd_t in_bcd,
	b2d_digit_if.source   digits
);
	import b2d_pkg::*;

	bcd_t bcd_q;
	idx_t idx_q;
	logic busy_q;
	logic out_fire;
	logic at_last;

	assign at_last  = (idx_q == '0);
	assign out_fire = busy_q && digits.ready;
	// the next value loads while the last digit of this one is taken
	assign in_ready = !busy_q || (digits.ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			idx_q  <= msd_index(in_bcd);
		end else if (out_fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bcd_q <= in_bcd;
		end
	end

	assign digits.valid      = busy_q;
	assign digits.digit_char = ASCII_ZERO + {2'b00, bcd_q[idx_q]};
	assign digits.last       = at_last;

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (digits.digit_char >= 6'd48 && digits.digit_char <= 6'd57))
		else $error("digit item outside ascii digit range");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !at_last) |=> (busy_q && idx_q == $past(idx_q) - 1'b1))
		else $error("digit run broken before its last item");

	a_no_load_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !at_last) |-> !in_ready)
		else $error("new value accepted in the middle of a run");

	a_leading_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !at_last && !$past(busy_q && !(digits.ready && at_last)))
		|-> (bcd_q[idx_q] != '0))
		else $error("run starts with a leading zero");

endmodule

FILE: design/binary_to_decimal_ascii_digits_core.sv
// Path: an operand loads the first stage, moves through each later stage register
//   in order and then into the serializer, which shows its first digit item; a stall
//   on the digit output can hold it in the stages.
// Throughput: one digit item per cycle while digits.ready is high; each operand
//   gives one item per decimal digit (1 to 5), set by the single serializer output.
// Reset: arst_n clears all valid bits and the serializer at once; no clearing pass.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digits_core
// Converts an unsigned binary operand to decimal through a pipeline of
// shift-add-3 stages and sends its digits as ASCII items.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_digits_core (
	input  logic        clk,
	input  logic        arst_n,
	b2d_value_if.sink   operand,
	b2d_digit_if.source digits
);
	import b2d_pkg::*;

	logic     valid_c [STAGES+1];
	logic     ready_c [STAGES+1];
	dd_word_t word_c  [STAGES+1];

	assign valid_c[0]    = operand.valid;
	assign operand.ready = ready_c[0];
	assign word_c[0].bcd = '0;
	assign word_c[0].bin = PAD_BITS'(operand.value);

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		b2d_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_word   (word_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_word  (word_c[i+1])
		);
	end

	b2d_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[STAGES]),
		.in_ready (ready_c[STAGES]),
		.in_bcd   (word_c[STAGES].bcd),
		.digits   (digits)
	);

endmodule
